/* rtl/skst_pkg.sv */
// Shared types and codes for the sorted key set table.
package skst_pkg;

   // Request operation codes; any other code behaves as a lookup.
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;

   // Fixed payload widths.
   localparam int unsigned REQ_KEY_W = 64;
   localparam int unsigned RSP_POS_W = 6;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_PRESENT = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_COMPARE,
      SEQ_COMMIT
   } seq_state_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic compare;     // latch less-than / equal flags
      logic shift_up;    // open a hole at the insert slot
      logic shift_down;  // close the hole at the removed slot
   } cell_ctrl_type;

endpackage

/* rtl/sorted_key_set_table.sv */
// Top level of the sorted key set table: request sequencer, cell chain, response register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   req_    | in        | req_valid/req_stall  | req_func[1:0], req_key[63:0]
//   rsp_    | out       | rsp_valid/rsp_stall  | rsp_status, rsp_found, rsp_position,
//           |           |                      | rsp_occupancy
//
// A request goes from idle, where it is accepted, to a compare state, where
// every cell compares its key with the request key, then to a commit state,
// where cells shift toward or away from the slot and the response register loads.
// The commit waits while a previous response is still stalled on rsp_.
// Synchronous active-high reset empties the table (count to zero); key cells
// are not cleared, since slots at or above the count are never looked at.
module sorted_key_set_table #(
   parameter int unsigned CAPACITY = 32,
   parameter int unsigned KEY_BITS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_func,
   input  logic [skst_pkg::REQ_KEY_W-1:0]        req_key,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_found,
   output logic [skst_pkg::RSP_POS_W-1:0]        rsp_position,
   output logic [skst_pkg::RSP_POS_W-1:0]        rsp_occupancy
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned POS_W = skst_pkg::RSP_POS_W;

   // Sequencer state
   skst_pkg::seq_state_type state_ff, state_in;

   // Captured request (payload, no reset)
   logic [1:0]          func_ff, func_in;
   logic [KEY_BITS-1:0] key_ff, key_in;

   // Occupancy
   logic [CNT_W-1:0] count_ff, count_in;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0] rsp_position_ff, rsp_position_in;
   logic [POS_W-1:0] rsp_occupancy_ff, rsp_occupancy_in;

   // Cell chain wiring
   skst_pkg::cell_ctrl_type cell_ctrl;
   logic [KEY_BITS-1:0]     cell_key [CAPACITY];
   logic [CAPACITY-1:0]     cell_lt;
   logic [CAPACITY-1:0]     cell_eq;
   logic [CAPACITY-1:0]     cell_occupied;
   logic [CAPACITY-1:0]     lower_lt;
   logic [CAPACITY-1:0]     boundary;

   logic             hit;
   logic             full;
   logic [POS_W-1:0] slot_pos;
   logic             commit_go;
   logic             do_insert;
   logic             do_remove;

   // ------------------------------------------------------------------
   // Cell i holds slot i; data moves only between neighbors, but the new key comes from the request register.
   // ------------------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_occupied[i] = count_ff > CNT_W'(i);

      if (i == 0) begin : g_first
         assign lower_lt[i] = 1'b1;
      end else begin : g_rest
         assign lower_lt[i] = cell_lt[i-1];
      end

      skst_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .match_key (key_ff),
         .occupied  (cell_occupied[i]),
         .lower_key ((i == 0) ? key_ff : cell_key[(i == 0) ? 0 : i-1]),
         .lower_lt  (lower_lt[i]),
         .upper_key ((i == CAPACITY-1) ? key_ff
                                       : cell_key[(i == CAPACITY-1) ? i : i+1]),
         .key_out   (cell_key[i]),
         .lt_out    (cell_lt[i]),
         .eq_out    (cell_eq[i])
      );
   end

   // The less-than flags form a prefix; the first cell past it is the slot.
   assign boundary = lower_lt & ~cell_lt;
   assign hit      = |cell_eq;
   assign full     = count_ff == CNT_W'(CAPACITY);

   always_comb begin
      slot_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (boundary[i]) begin
            slot_pos = slot_pos | POS_W'(i);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequencer and response
   // ------------------------------------------------------------------
   assign commit_go = (state_ff == skst_pkg::SEQ_COMMIT) && (!rsp_valid_ff || !rsp_stall);
   assign do_insert = (func_ff == skst_pkg::FUNC_INSERT) && !hit && !full;
   assign do_remove = (func_ff == skst_pkg::FUNC_REMOVE) && hit;

   always_comb begin
      state_in          = state_ff;
      func_in           = func_ff;
      key_in            = key_ff;
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_found_in      = rsp_found_ff;
      rsp_position_in   = rsp_position_ff;
      rsp_occupancy_in  = rsp_occupancy_ff;
      cell_ctrl         = '0;
      req_stall         = 1'b1;

      unique case (state_ff)
         skst_pkg::SEQ_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               func_in  = req_func;
               key_in   = req_key[KEY_BITS-1:0];
               state_in = skst_pkg::SEQ_COMPARE;
            end
         end
         skst_pkg::SEQ_COMPARE: begin
            cell_ctrl.compare = 1'b1;
            state_in          = skst_pkg::SEQ_COMMIT;
         end
         skst_pkg::SEQ_COMMIT: begin
            if (commit_go) begin
               cell_ctrl.shift_up   = do_insert;
               cell_ctrl.shift_down = do_remove;
               rsp_valid_in         = 1'b1;
               rsp_found_in         = hit;
               rsp_position_in      = '0;
               if (func_ff == skst_pkg::FUNC_INSERT) begin
                  if (hit) begin
                     rsp_status_in   = skst_pkg::ST_PRESENT;
                     rsp_position_in = slot_pos;
                  end else if (full) begin
                     rsp_status_in   = skst_pkg::ST_FULL;
                  end else begin
                     rsp_status_in   = skst_pkg::ST_DONE;
                     rsp_position_in = slot_pos;
                     count_in        = count_ff + CNT_W'(1);
                  end
               end else if (func_ff == skst_pkg::FUNC_REMOVE) begin
                  if (hit) begin
                     rsp_status_in   = skst_pkg::ST_DONE;
                     rsp_position_in = slot_pos;
                     count_in        = count_ff - CNT_W'(1);
                  end else begin
                     rsp_status_in   = skst_pkg::ST_ABSENT;
                  end
               end else begin
                  // lookup, and the spare code
                  rsp_status_in   = hit ? skst_pkg::ST_DONE : skst_pkg::ST_ABSENT;
                  rsp_position_in = hit ? slot_pos : '0;
               end
               rsp_occupancy_in = POS_W'(count_in);
               state_in         = skst_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = skst_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skst_pkg::SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff          <= func_in;
      key_ff           <= key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_found_ff     <= rsp_found_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

`ifndef SYNTHESIS
   // Count never runs past the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("key count exceeds capacity");

   // Keys are unique, so at most one cell matches.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skst_pkg::SEQ_COMMIT) |-> $onehot0(cell_eq))
      else $error("more than one cell matches the key");

   // Sorted order: less-than flags form a prefix of the chain.
   a_lt_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skst_pkg::SEQ_COMMIT) |-> ((cell_lt & ~lower_lt) == '0))
      else $error("cell order broken");

   // Count moves only on a commit.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !commit_go |=> $stable(count_ff))
      else $error("count changed outside a commit");

   // A commit never overwrites a response that is still stalled.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !commit_go)
      else $error("response overwritten while stalled");
`endif

endmodule

/* rtl/skst_cell.sv */
// One slot of the sorted key chain: holds a key and its compare flags.
module skst_cell #(
   parameter int unsigned KEY_BITS = 64
) (
   input  logic                    clock,
   input  skst_pkg::cell_ctrl_type ctrl,
   input  logic [KEY_BITS-1:0]     match_key,
   input  logic                    occupied,
   input  logic [KEY_BITS-1:0]     lower_key,
   input  logic                    lower_lt,
   input  logic [KEY_BITS-1:0]     upper_key,
   output logic [KEY_BITS-1:0]     key_out,
   output logic                    lt_out,
   output logic                    eq_out
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                lt_ff, lt_in;
   logic                eq_ff, eq_in;

   always_comb begin
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      key_in = key_ff;
      if (ctrl.compare) begin
         lt_in = occupied && (key_ff < match_key);
         eq_in = occupied && (key_ff == match_key);
      end
      // Below the slot keys stay; an insert puts the new key in the slot.
      if (ctrl.shift_up && !lt_ff) begin
         key_in = lower_lt ? match_key : lower_key;
      end else if (ctrl.shift_down && !lt_ff) begin
         key_in = upper_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key_out = key_ff;
   assign lt_out  = lt_ff;
   assign eq_out  = eq_ff;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the sorted key set table: random traffic with a shadow set.
module tb;

   // The table is built with its default size; the shadow set mirrors it.
   localparam int unsigned TABLE_SLOTS = 32;
   localparam logic [63:0] KEY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   // Codes the package leaves unnamed: 2 is lookup, 3 is unused and acts as lookup.
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;
   localparam logic [1:0] FUNC_SPARE  = 2'd3;

   localparam int RANDOM_REQUESTS = 1950;
   localparam int KEY_POOL_SIZE   = 44;

   typedef struct {
      logic [1:0]  func;
      logic [63:0] key;
   } set_request_type;

   typedef struct {
      skst_pkg::status_type status;
      logic                 found;
      logic [5:0]           position;
      logic [5:0]           occupancy;
   } set_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_LOOKUP;
   logic [63:0] req_key = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_found;
   logic [5:0]  rsp_position;
   logic [5:0]  rsp_occupancy;

   sorted_key_set_table #(
      .CAPACITY(TABLE_SLOTS),
      .KEY_BITS(64)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_position  (rsp_position),
      .rsp_occupancy (rsp_occupancy)
   );

   // Items waiting for the driver, and replies owed by the table in order.
   set_request_type requests_to_send[$];
   set_reply_type   replies_due[$];

   // Shadow copy of the set: ascending keys in slots 0..shadow_count-1.
   logic [63:0]  shadow_keys [0:TABLE_SLOTS-1];
   int           shadow_count = 0;

   logic [63:0]  key_pool [0:KEY_POOL_SIZE-1];
   int           total_requests = 0;
   int           accepted_count = 0;
   int           mismatch_count = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Applies one request to the shadow set and returns the reply it owes.
   function automatic set_reply_type predict_reply(logic [1:0] func, logic [63:0] key);
      set_reply_type r;
      int            slot;
      bit            hit;
      slot = 0;
      while (slot < shadow_count && shadow_keys[slot] < key)
         slot++;
      hit = (slot < shadow_count) && (shadow_keys[slot] == key);
      r.found    = hit;
      r.position = '0;
      r.status   = skst_pkg::ST_ABSENT;
      if (func == skst_pkg::FUNC_INSERT) begin
         if (hit) begin
            r.status   = skst_pkg::ST_PRESENT;
            r.position = slot[5:0];
         end else if (shadow_count >= TABLE_SLOTS) begin
            r.status = skst_pkg::ST_FULL;
         end else begin
            for (int i = shadow_count; i > slot; i--)
               shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[slot] = key;
            shadow_count++;
            r.status   = skst_pkg::ST_DONE;
            r.position = slot[5:0];
         end
      end else if (func == skst_pkg::FUNC_REMOVE) begin
         if (hit) begin
            for (int i = slot; i + 1 < shadow_count; i++)
               shadow_keys[i] = shadow_keys[i+1];
            shadow_count--;
            r.status   = skst_pkg::ST_DONE;
            r.position = slot[5:0];
         end
      end else if (hit) begin
         // lookup and the unused code behave the same
         r.status   = skst_pkg::ST_DONE;
         r.position = slot[5:0];
      end
      r.occupancy = shadow_count[5:0];
      return r;
   endfunction

   task automatic queue_request(logic [1:0] func, logic [63:0] key);
      set_request_type item;
      item.func = func;
      item.key  = key;
      requests_to_send.push_back(item);
   endtask

   // Mostly keys from a small pool so that hits, duplicates and a full table
   // are common; the rest are fully random and nearly always miss.
   function automatic logic [63:0] pick_key();
      if ($urandom_range(0, 99) < 78)
         return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      return {$urandom, $urandom};
   endfunction

   task automatic report_mismatch(string field, int unsigned want, int unsigned got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // ------------------------------------------------------------------
   // Stimulus: a directed prelude, then phases that lean toward filling or
   // draining the table so it swings between empty and full many times.
   // ------------------------------------------------------------------
   initial begin
      logic [63:0] cluster_base;
      int          phase_len;
      int          phase_kind;
      int          roll;
      int          made;
      logic [1:0]  func;

      key_pool[0] = '0;
      key_pool[1] = KEY_MAX;
      key_pool[2] = 64'd1;
      key_pool[3] = KEY_MAX - 64'd1;
      key_pool[4] = 64'h8000_0000_0000_0000;
      key_pool[5] = 64'h7FFF_FFFF_FFFF_FFFF;
      // neighbors differing only in the low bits test the ordering compare
      cluster_base = {$urandom, $urandom};
      for (int i = 6; i < 16; i++)
         key_pool[i] = cluster_base + 64'(i);
      for (int i = 16; i < KEY_POOL_SIZE; i++)
         key_pool[i] = {$urandom, $urandom};

      // empty table: remove and lookup both miss
      queue_request(FUNC_LOOKUP, 64'd5);
      queue_request(skst_pkg::FUNC_REMOVE, 64'd5);
      // inserts out of order, extremes included, then a duplicate
      queue_request(skst_pkg::FUNC_INSERT, 64'd100);
      queue_request(skst_pkg::FUNC_INSERT, 64'd0);
      queue_request(skst_pkg::FUNC_INSERT, KEY_MAX);
      queue_request(skst_pkg::FUNC_INSERT, 64'd50);
      queue_request(skst_pkg::FUNC_INSERT, 64'd100);
      queue_request(FUNC_LOOKUP, 64'd0);
      queue_request(FUNC_LOOKUP, KEY_MAX);
      queue_request(FUNC_LOOKUP, 64'd51);
      // unused code acts as a lookup, hit and miss
      queue_request(FUNC_SPARE, 64'd50);
      queue_request(FUNC_SPARE, 64'd7);
      // remove from middle, front and back, then a repeat that misses
      queue_request(skst_pkg::FUNC_REMOVE, 64'd50);
      queue_request(skst_pkg::FUNC_REMOVE, 64'd0);
      queue_request(skst_pkg::FUNC_REMOVE, KEY_MAX);
      queue_request(skst_pkg::FUNC_REMOVE, 64'd50);
      queue_request(FUNC_LOOKUP, 64'd100);
      queue_request(skst_pkg::FUNC_REMOVE, 64'd100);
      queue_request(skst_pkg::FUNC_INSERT, KEY_MAX);
      queue_request(skst_pkg::FUNC_REMOVE, KEY_MAX);

      made = 0;
      while (made < RANDOM_REQUESTS) begin
         phase_len  = $urandom_range(20, 90);
         phase_kind = $urandom_range(0, 2);   // 0 fill, 1 drain, 2 mixed
         for (int n = 0; n < phase_len; n++) begin
            roll = $urandom_range(0, 99);
            case (phase_kind)
               0: begin
                  func = (roll < 65) ? skst_pkg::FUNC_INSERT :
                         (roll < 80) ? skst_pkg::FUNC_REMOVE :
                         (roll < 95) ? FUNC_LOOKUP : FUNC_SPARE;
               end
               1: begin
                  func = (roll < 15) ? skst_pkg::FUNC_INSERT :
                         (roll < 75) ? skst_pkg::FUNC_REMOVE :
                         (roll < 95) ? FUNC_LOOKUP : FUNC_SPARE;
               end
               default: begin
                  func = (roll < 35) ? skst_pkg::FUNC_INSERT :
                         (roll < 65) ? skst_pkg::FUNC_REMOVE :
                         (roll < 92) ? FUNC_LOOKUP : FUNC_SPARE;
               end
            endcase
            queue_request(func, pick_key());
         end
         made += phase_len;
      end
      total_requests = requests_to_send.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // drain: every transfer accepted, every reply seen, then some slack
      while (accepted_count < total_requests || replies_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && replies_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: bursts of back-to-back requests separated by random gaps. A
   // request held under stall keeps its payload. Each transfer is run
   // through the shadow set at the edge where it is accepted.
   // ------------------------------------------------------------------
   int gap_left;
   int burst_left;

   always @(posedge clock) begin
      set_request_type next_item;
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   = 0;
         burst_left = 1;
      end else begin
         if (req_valid && !req_stall) begin
            replies_due.push_back(predict_reply(req_func, req_key));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (requests_to_send.size() != 0) begin
               next_item = requests_to_send.pop_front();
               req_func  <= next_item.func;
               req_key   <= next_item.key;
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  // now and then a long run with no gaps at all
                  if ($urandom_range(0, 99) < 25) begin
                     burst_left = $urandom_range(50, 150);
                     gap_left   = 0;
                  end else begin
                     burst_left = $urandom_range(1, 12);
                     gap_left   = $urandom_range(0, 7);
                  end
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver stall: a mode picked at random, from never stalling
   // through random light and heavy stalls to a fixed periodic pattern.
   // ------------------------------------------------------------------
   int stall_cycle = 0;
   int stall_mode  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_cycle = 0;
         stall_mode  = 0;
      end else begin
         stall_cycle++;
         if (stall_cycle % 64 == 0)
            stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 99) < 20);
            2:       rsp_stall <= ($urandom_range(0, 99) < 70);
            default: rsp_stall <= (stall_cycle % 8 < 3);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Monitor: each reply transfer is checked field by field against the
   // oldest owed reply.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      set_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: reply transfer with none owed, expected none, actual status %0d",
                     $time, rsp_status);
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
            if (rsp_found !== want.found)
               report_mismatch("found", want.found, rsp_found);
            if (rsp_position !== want.position)
               report_mismatch("position", want.position, rsp_position);
            if (rsp_occupancy !== want.occupancy)
               report_mismatch("occupancy", want.occupancy, rsp_occupancy);
         end
      end
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
